/* hw/rtl/circular_message_mailbox_unit_assert.svh */
// assertion macros for the circular message mailbox
`ifndef CIRCULAR_MESSAGE_MAILBOX_UNIT_ASSERT_SVH
`define CIRCULAR_MESSAGE_MAILBOX_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CMM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mailbox assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define CMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mailbox assertion failed");

`endif

/* hw/rtl/cmm_pkg.sv */
// types and constants shared by the mailbox modules
package cmm_pkg;

  // number of slots and derived widths
  localparam int unsigned SLOT_COUNT = 32;
  localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WORD_W     = 32;

  // request operations
  typedef enum logic [1:0] {
    OP_POST  = 2'd0,
    OP_CHECK = 2'd1,
    OP_FETCH = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // one slot: code plus three parameter words
  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
    logic [WORD_W-1:0] third;
  } slot_t;

  // control from the sequencer to the slot store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             kill;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic             clr_all;
  } store_req_t;

endpackage

/* hw/rtl/circular_message_mailbox_unit.sv */
// Circular message mailbox: SLOT_COUNT slots of a code and three words, one request at a
// time. Post, check and fetch scan the slot memory one slot per cycle through its single
// read port with one shared compare unit; a scan stops at the first hit or after all
// SLOT_COUNT slots, and its result passes through the done state into the output register.
// Clear goes straight to the done state. A result still waiting in the output register
// holds the next one back until it is taken. A new request is taken while the previous
// result still waits in the output register.
module circular_message_mailbox_unit import cmm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [WORD_W-1:0] msg_code_i,
  input  logic [WORD_W-1:0] arg_first_i,
  input  logic [WORD_W-1:0] arg_second_i,
  input  logic [WORD_W-1:0] arg_third_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [WORD_W-1:0] got_code_o,
  output logic [WORD_W-1:0] got_first_o,
  output logic [WORD_W-1:0] got_second_o,
  output logic [WORD_W-1:0] got_third_o
);

`include "circular_message_mailbox_unit_assert.svh"

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  slot_t            req_slot_q, req_slot_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] issue_cnt_q, issue_cnt_d;
  logic [IDX_W-1:0] scan_start_q, scan_start_d;
  logic             rd_pend_q, rd_pend_d;
  logic             rd_last_q, rd_last_d;
  logic [IDX_W-1:0] rd_pos_q, rd_pos_d;
  logic             res_ok_q, res_ok_d;
  slot_t            res_slot_q, res_slot_d;
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q, out_ok_d;
  slot_t            out_slot_q, out_slot_d;
  store_req_t       store_req;
  slot_t            rd_slot;
  logic             in_acc;
  logic             code_zero;
  logic             all_eq;
  logic             hit;
  logic             issue_en;

  cmm_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (rd_slot)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // shared compare unit on the slot just read
  assign code_zero = (rd_slot.code == '0);
  assign all_eq    = (rd_slot == req_slot_q);

  always_comb begin
    hit = 1'b0;
    unique case (op_q)
      OP_POST:  hit = rd_pend_q && code_zero;
      OP_CHECK: hit = rd_pend_q && all_eq;
      OP_FETCH: hit = rd_pend_q && !code_zero;
      default:  hit = 1'b0;
    endcase
  end

  assign issue_en = (state_q == ST_SCAN) && (issue_cnt_q != CNT_W'(SLOT_COUNT)) && !hit;

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_slot_d   = req_slot_q;
    pos_d        = pos_q;
    issue_cnt_d  = issue_cnt_q;
    scan_start_d = scan_start_q;
    rd_pend_d    = 1'b0;
    rd_last_d    = 1'b0;
    rd_pos_d     = rd_pos_q;
    res_ok_d     = res_ok_q;
    res_slot_d   = res_slot_q;
    store_req    = '0;
    store_req.rd_addr = pos_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d              = op_e'(opcode_i);
          req_slot_d.code   = msg_code_i;
          req_slot_d.first  = arg_first_i;
          req_slot_d.second = arg_second_i;
          req_slot_d.third  = arg_third_i;
          issue_cnt_d       = '0;
          res_ok_d          = 1'b0;
          res_slot_d        = '0;
          if (op_e'(opcode_i) == OP_CLEAR) begin
            store_req.clr_all = 1'b1;
            scan_start_d      = '0;
            res_ok_d          = 1'b1;
            state_d           = ST_DONE;
          end else begin
            pos_d   = (op_e'(opcode_i) == OP_CHECK) ? '0 : scan_start_q;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue the next slot read
        if (issue_en) begin
          store_req.rd_en = 1'b1;
          rd_pend_d       = 1'b1;
          rd_pos_d        = pos_q;
          rd_last_d       = (issue_cnt_q == CNT_W'(SLOT_COUNT - 1));
          issue_cnt_d     = issue_cnt_q + CNT_W'(1);
          pos_d           = (pos_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : pos_q + IDX_W'(1);
        end
        // act on the compared slot
        if (hit) begin
          res_ok_d          = 1'b1;
          store_req.wr_addr = rd_pos_q;
          if (op_q == OP_POST) begin
            store_req.wr_en   = 1'b1;
            store_req.wr_data = req_slot_q;
          end else if (op_q == OP_FETCH) begin
            store_req.kill = 1'b1;
            scan_start_d   = rd_pos_q;
            res_slot_d     = rd_slot;
          end
          state_d = ST_DONE;
        end else if (rd_pend_q && rd_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_slot_d  = out_slot_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_ok_d    = res_ok_q;
      out_slot_d  = res_slot_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_cnt_q  <= '0;
      scan_start_q <= '0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_cnt_q  <= issue_cnt_d;
      scan_start_q <= scan_start_d;
      rd_pend_q    <= rd_pend_d;
      rd_last_q    <= rd_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    req_slot_q <= req_slot_d;
    pos_q      <= pos_d;
    rd_pos_q   <= rd_pos_d;
    res_ok_q   <= res_ok_d;
    res_slot_q <= res_slot_d;
    out_ok_q   <= out_ok_d;
    out_slot_q <= out_slot_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign got_code_o   = out_slot_q.code;
  assign got_first_o  = out_slot_q.first;
  assign got_second_o = out_slot_q.second;
  assign got_third_o  = out_slot_q.third;

  // checks
  `CMM_ASSERT_NOW(a_issue_bound, 1'b1, issue_cnt_q <= CNT_W'(SLOT_COUNT))
  `CMM_ASSERT_NEXT(a_clear_done, in_acc && (opcode_i == OP_CLEAR), (state_q == ST_DONE) && res_ok_q)
  `CMM_ASSERT_NOW(a_miss_zero, (state_q == ST_DONE) && !res_ok_q, res_slot_q == '0)

endmodule

/* hw/rtl/cmm_slot_store.sv */
// slot memory with per-slot written flags and a registered read port
module cmm_slot_store import cmm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output slot_t      rd_data_o
);

  slot_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written_q, written_d;
  slot_t                 rd_raw_q;
  logic                  rd_written_q;

  // written flags: an unwritten slot reads as all zero
  always_comb begin
    written_d = written_q;
    if (req_i.clr_all) begin
      written_d = '0;
    end else if (req_i.wr_en) begin
      written_d[req_i.wr_addr] = 1'b1;
    end else if (req_i.kill) begin
      written_d[req_i.wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else begin
      written_q <= written_d;
    end
  end

  // flag sampled with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_written_q <= 1'b0;
    end else if (req_i.rd_en) begin
      rd_written_q <= written_q[req_i.rd_addr];
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_written_q ? rd_raw_q : '0;

endmodule
